### rtl/core/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// types, codes and the crc step shared by the fragment reassembler core
// ----------------------------------------------------------------------------
package cfr_pkg;

  typedef enum logic [1:0] {
    ACT_HEADER = 2'd0,
    ACT_DATA   = 2'd1,
    ACT_READ   = 2'd2,
    ACT_GRANT  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_CREDIT = 2'd0,
    KIND_QFULL  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_GRANT  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_NONE = 2'd0,
    STAT_OK   = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  localparam logic [1:0] REG_WINDOW  = 2'd0;
  localparam logic [1:0] REG_NETCH   = 2'd1;
  localparam logic [1:0] REG_SEED    = 2'd2;

  localparam logic [7:0]  WINDOW_RESET = 8'd4;
  localparam logic [2:0]  NETCH_RESET  = 3'd1;
  localparam logic [15:0] SEED_RESET   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;

  typedef struct packed {
    action_t     action;
    logic [7:0]  channel;
    logic [7:0]  transaction;
    logic [7:0]  fragment_number;
    logic        first_flag;
    logic        last_flag;
    logic [15:0] total_length;
    logic [15:0] message_crc;
    logic [7:0]  payload_len;
    logic [7:0]  data_byte;
    logic [11:0] read_index;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  credit_channel;
    logic [7:0]  credit_count;
    status_t     message_status;
    logic [12:0] message_length;
    logic [7:0]  read_data;
  } result_t;

  // crc-16 ccitt, msb first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/credit_fragment_reassembler_core.sv
// ----------------------------------------------------------------------------
// credit_fragment_reassembler_core
// credit checked fragment reassembly with crc-16, buffered byte reads
// ----------------------------------------------------------------------------
//  port group  dir  handshake          contents
//  s_*         in   tvalid/tready      header, data byte, read or grant word
//  m_*         out  tvalid/tready      credit, fault, read data or grant word
//  p*          in   psel/penable       apb registers window, channel, seed
//
//  one word per cycle sustained while m_tready is high; a result word is formed
//  in the stage register from the credit and buffer ram reads, then registered
//  reset clears all control state at once; credits use per-entry valid bits,
//  the buffer has no clearing pass
//  m_tready low holds the result, the next word waits in the stage register
//  and s_tready drops only once both are full
// ----------------------------------------------------------------------------
module credit_fragment_reassembler_core
  import cfr_pkg::*;
#(
  parameter int CHANNELS      = 8,
  parameter int MESSAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // channel, transaction, fragment_number, first_flag, total_length,
  // message_crc, payload_len, data_byte, read_index, zero pad
  input  logic [87:0] s_tdata,
  // action
  input  logic [1:0]  s_tuser,
  // last_flag
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // credit_channel, credit_count, message_status, message_length,
  // read_data, zero pad
  output logic [39:0] m_tdata,
  // kind
  output logic [1:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW = $clog2(MESSAGE_BYTES);
  localparam int LW = $clog2(MESSAGE_BYTES + 1);
  localparam int SW = ((LW > 8) ? LW : 8) + 1;
  localparam int RW = (AW > 12) ? AW : 12;
  localparam logic [8:0]  CH_LIMIT  = 9'(CHANNELS);
  localparam logic [15:0] MSG_LIMIT = 16'(MESSAGE_BYTES);

  // configuration
  logic [7:0]  credit_window;
  logic [2:0]  network_channel;
  logic [15:0] crc_seed;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit_window   <= WINDOW_RESET;
      network_channel <= NETCH_RESET;
      crc_seed        <= SEED_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WINDOW: credit_window   <= pwdata[7:0];
        REG_NETCH:  network_channel <= pwdata[2:0];
        REG_SEED:   crc_seed        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WINDOW: prdata = {24'd0, credit_window};
      REG_NETCH:  prdata = {29'd0, network_channel};
      REG_SEED:   prdata = {16'd0, crc_seed};
      default:    prdata = 32'd0;
    endcase
  end

  // input decode
  item_t in_item;
  assign in_item.action          = action_t'(s_tuser);
  assign in_item.channel         = s_tdata[7:0];
  assign in_item.transaction     = s_tdata[15:8];
  assign in_item.fragment_number = s_tdata[23:16];
  assign in_item.first_flag      = s_tdata[24];
  assign in_item.last_flag       = s_tlast;
  assign in_item.total_length    = s_tdata[40:25];
  assign in_item.message_crc     = s_tdata[56:41];
  assign in_item.payload_len     = s_tdata[64:57];
  assign in_item.data_byte       = s_tdata[72:65];
  assign in_item.read_index      = s_tdata[84:73];

  // stage register and output register
  item_t   p;
  logic    p_valid;
  logic    fire;
  logic    accept;
  result_t res;
  logic    res_valid;
  result_t o_res;
  logic    o_valid;

  assign fire     = p_valid && (!o_valid || m_tready);
  assign s_tready = !p_valid || fire;
  assign accept   = s_tvalid && s_tready;

  // reassembly state
  logic [7:0]          bytes_pending, bytes_pending_next;
  logic                keep_bytes, keep_bytes_next;
  logic                frag_last, frag_last_next;
  logic [CW-1:0]       frag_ch, frag_ch_next;
  logic [7:0]          frag_credit, frag_credit_next;
  logic [LW-1:0]       rx_len, rx_len_next;
  logic [LW-1:0]       exp_len, exp_len_next;
  logic [15:0]         exp_crc, exp_crc_next;
  logic [15:0]         run_crc, run_crc_next;
  logic [7:0]          cur_trans, cur_trans_next;
  logic [7:0]          next_frag, next_frag_next;
  logic                assembling, assembling_next;

  // credit store
  logic [CHANNELS-1:0] cvalid;
  logic [7:0]          cbase;
  logic                cram_we;
  logic [7:0]          cram_wdata;
  logic [7:0]          cram_q;
  logic                cwq_valid;
  logic [CW-1:0]       cwq_addr;
  logic [7:0]          cwq_data;
  logic [CW-1:0]       ch_idx;
  logic [7:0]          cur_credit;
  logic                grant;

  // message buffer
  logic                bram_we;
  logic [AW-1:0]       bram_waddr;
  logic [7:0]          bram_q;
  logic [RW-1:0]       in_ridx_w;
  logic [RW-1:0]       p_ridx_w;
  logic [AW-1:0]       p_raddr;
  logic                bwq_valid;
  logic [AW-1:0]       bwq_addr;
  logic [7:0]          bwq_data;
  logic [7:0]          buf_byte;

  assign in_ridx_w = RW'(in_item.read_index);
  assign p_ridx_w  = RW'(p.read_index);
  assign p_raddr   = p_ridx_w[AW-1:0];
  assign ch_idx    = p.channel[CW-1:0];

  cfr_ram #(.WIDTH(8), .DEPTH(CHANNELS)) u_credit_ram (
    .clk   (clk),
    .we    (cram_we),
    .waddr (frag_ch_next),
    .wdata (cram_wdata),
    .re    (accept),
    .raddr (in_item.channel[CW-1:0]),
    .rdata (cram_q)
  );

  cfr_ram #(.WIDTH(8), .DEPTH(MESSAGE_BYTES)) u_buffer_ram (
    .clk   (clk),
    .we    (bram_we),
    .waddr (bram_waddr),
    .wdata (p.data_byte),
    .re    (accept),
    .raddr (in_ridx_w[AW-1:0]),
    .rdata (bram_q)
  );

  // unwritten credit entries read the grant base; forward the last write where the ram read went out at the same edge
  always_comb begin
    if (!cvalid[ch_idx]) begin
      cur_credit = cbase;
    end else if (cwq_valid && cwq_addr == ch_idx) begin
      cur_credit = cwq_data;
    end else begin
      cur_credit = cram_q;
    end
    if (bwq_valid && bwq_addr == p_raddr) begin
      buf_byte = bwq_data;
    end else begin
      buf_byte = bram_q;
    end
  end

  always_comb begin
    logic          ch_ok;
    logic          do_finish;
    logic [7:0]    fin_credit;
    logic [7:0]    new_credit;
    logic [7:0]    ch_wide;
    logic [SW-1:0] len_sum;
    status_t       status;
    logic [12:0]   mlen;

    bytes_pending_next = bytes_pending;
    keep_bytes_next    = keep_bytes;
    frag_last_next     = frag_last;
    frag_ch_next       = frag_ch;
    frag_credit_next   = frag_credit;
    rx_len_next        = rx_len;
    exp_len_next       = exp_len;
    exp_crc_next       = exp_crc;
    run_crc_next       = run_crc;
    cur_trans_next     = cur_trans;
    next_frag_next     = next_frag;
    assembling_next    = assembling;
    res                = '0;
    res_valid          = 1'b0;
    cram_we            = 1'b0;
    cram_wdata         = cur_credit;
    bram_we            = 1'b0;
    bram_waddr         = rx_len[AW-1:0];
    grant              = 1'b0;
    do_finish          = 1'b0;
    fin_credit         = frag_credit;
    new_credit         = frag_credit;
    ch_wide            = 8'd0;
    status             = STAT_NONE;
    mlen               = 13'd0;
    ch_ok              = (p.channel != 8'd0) && ({1'b0, p.channel} < CH_LIMIT);
    len_sum            = '0;

    case (p.action)
      ACT_HEADER: begin
        if (bytes_pending == 8'd0) begin
          bytes_pending_next = p.payload_len;
          keep_bytes_next    = 1'b0;
          frag_last_next     = 1'b0;
          if (!ch_ok || cur_credit == 8'd0) begin
            frag_ch_next       = '0;
            res_valid          = 1'b1;
            res.kind           = KIND_QFULL;
            res.credit_channel = p.channel[2:0];
          end else begin
            frag_ch_next     = ch_idx;
            frag_credit_next = cur_credit - 8'd1;
            cram_wdata       = cur_credit - 8'd1;
            if (p.channel != {5'd0, network_channel} || p.total_length > MSG_LIMIT) begin
              assembling_next = 1'b0;
            end else begin
              if (p.first_flag) begin
                rx_len_next     = '0;
                exp_len_next    = LW'(p.total_length);
                exp_crc_next    = p.message_crc;
                cur_trans_next  = p.transaction;
                next_frag_next  = 8'd0;
                run_crc_next    = crc_seed;
                assembling_next = 1'b1;
              end
              len_sum = SW'(rx_len_next) + SW'(p.payload_len);
              if (!assembling_next || p.transaction != cur_trans_next ||
                  p.fragment_number != next_frag_next || len_sum > SW'(exp_len_next)) begin
                assembling_next = 1'b0;
              end else begin
                keep_bytes_next = 1'b1;
                frag_last_next  = p.last_flag;
                next_frag_next  = next_frag_next + 8'd1;
              end
            end
            if (p.payload_len == 8'd0) begin
              do_finish  = 1'b1;
              fin_credit = cur_credit - 8'd1;
            end else begin
              cram_we = 1'b1;
            end
          end
        end
      end
      ACT_DATA: begin
        if (bytes_pending != 8'd0) begin
          if (keep_bytes && rx_len < LW'(MESSAGE_BYTES)) begin
            bram_we      = 1'b1;
            run_crc_next = crc16_byte(run_crc, p.data_byte);
            rx_len_next  = rx_len + LW'(1);
          end
          bytes_pending_next = bytes_pending - 8'd1;
          if (bytes_pending == 8'd1) begin
            do_finish = 1'b1;
          end
        end
      end
      ACT_READ: begin
        res_valid = 1'b1;
        res.kind  = KIND_READ;
        if (17'(p.read_index) < 17'(MESSAGE_BYTES)) begin
          res.read_data = buf_byte;
        end
      end
      ACT_GRANT: begin
        grant             = 1'b1;
        frag_credit_next  = credit_window;
        res_valid         = 1'b1;
        res.kind          = KIND_GRANT;
        res.credit_count  = credit_window;
      end
      default: ;
    endcase

    if (do_finish) begin
      if (keep_bytes_next && frag_last_next) begin
        if (rx_len_next == exp_len_next && run_crc_next == exp_crc_next) begin
          status = STAT_OK;
        end else begin
          status = STAT_BAD;
        end
        mlen            = 13'(rx_len_next);
        assembling_next = 1'b0;
      end
      keep_bytes_next = 1'b0;
      frag_last_next  = 1'b0;
      if (frag_ch_next != '0) begin
        new_credit         = (fin_credit < credit_window) ? fin_credit + 8'd1 : fin_credit;
        frag_credit_next   = new_credit;
        cram_we            = 1'b1;
        cram_wdata         = new_credit;
        ch_wide            = 8'(frag_ch_next);
        res_valid          = 1'b1;
        res.kind           = KIND_CREDIT;
        res.credit_channel = ch_wide[2:0];
        res.credit_count   = new_credit;
        res.message_status = status;
        res.message_length = mlen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid       <= 1'b0;
      o_valid       <= 1'b0;
      bytes_pending <= 8'd0;
      keep_bytes    <= 1'b0;
      frag_last     <= 1'b0;
      frag_ch       <= '0;
      frag_credit   <= 8'd0;
      rx_len        <= '0;
      exp_len       <= '0;
      exp_crc       <= 16'd0;
      run_crc       <= SEED_RESET;
      cur_trans     <= 8'd0;
      next_frag     <= 8'd0;
      assembling    <= 1'b0;
      cvalid        <= '0;
      cbase         <= 8'd0;
      cwq_valid     <= 1'b0;
      bwq_valid     <= 1'b0;
    end else begin
      if (accept) begin
        p_valid <= 1'b1;
      end else if (fire) begin
        p_valid <= 1'b0;
      end
      if (fire && res_valid) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
      if (fire) begin
        bytes_pending <= bytes_pending_next;
        keep_bytes    <= keep_bytes_next;
        frag_last     <= frag_last_next;
        frag_ch       <= frag_ch_next;
        frag_credit   <= frag_credit_next;
        rx_len        <= rx_len_next;
        exp_len       <= exp_len_next;
        exp_crc       <= exp_crc_next;
        run_crc       <= run_crc_next;
        cur_trans     <= cur_trans_next;
        next_frag     <= next_frag_next;
        assembling    <= assembling_next;
        if (grant) begin
          cvalid    <= '0;
          cbase     <= credit_window;
          cwq_valid <= 1'b0;
        end else if (cram_we) begin
          cvalid[frag_ch_next] <= 1'b1;
          cwq_valid            <= 1'b1;
        end
        if (bram_we) begin
          bwq_valid <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      p <= in_item;
    end
    if (fire && res_valid) begin
      o_res <= res;
    end
    if (fire && cram_we) begin
      cwq_addr <= frag_ch_next;
      cwq_data <= cram_wdata;
    end
    if (fire && bram_we) begin
      bwq_addr <= bram_waddr;
      bwq_data <= p.data_byte;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tuser  = o_res.kind;
  assign m_tdata  = {6'd0, o_res.read_data, o_res.message_length, o_res.message_status,
                     o_res.credit_count, o_res.credit_channel};

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (p_valid && o_valid && !m_tready))
    else $error("input stalled without a full pipeline");

  a_write_within_message: assert property (@(posedge clk) disable iff (rst)
    (fire && bram_we) |-> (rx_len < exp_len))
    else $error("buffer write beyond the expected length");

  a_keep_implies_assembling: assert property (@(posedge clk) disable iff (rst)
    keep_bytes |-> assembling)
    else $error("bytes kept outside an assembly");

  a_fault_has_no_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_QFULL) |-> (m_tdata[25:3] == 23'd0))
    else $error("queue full word carries a count or status");

endmodule

### rtl/core/cfr_ram.sv
// ----------------------------------------------------------------------------
// cfr_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### tb/tb_credit_fragment_reassembler_core.sv
// ----------------------------------------------------------------------------
// tb_credit_fragment_reassembler_core
// checks credit accounting, fragment reassembly, crc-16 delivery status,
// buffer reads and grants against a cycle-free model of the core, with
// random gaps on the input stream, random stalls on the output stream and
// register changes between traffic phases
// ----------------------------------------------------------------------------
module tb_credit_fragment_reassembler_core;
  import cfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH       = 8;
  localparam int BUF_BYTES = 4096;

  typedef enum int {
    FLAW_NONE, FLAW_CRC, FLAW_LONG, FLAW_SHORT, FLAW_ORDER, FLAW_TAG, FLAW_NOFIRST,
    FLAW_CUT
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  credit_fragment_reassembler_core #(
    .CHANNELS(NCH),
    .MESSAGE_BYTES(BUF_BYTES)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // register copies
  logic [7:0]  window = WINDOW_RESET;
  logic [2:0]  net_ch = NETCH_RESET;
  logic [15:0] seed   = SEED_RESET;

  // reassembly state
  logic [7:0]  credits [NCH] = '{default: 8'd0};
  logic [7:0]  msg_bytes [BUF_BYTES];
  logic [12:0] rx_len = '0;
  logic [12:0] exp_len = '0;
  logic [15:0] exp_crc = '0;
  logic [15:0] run_crc = 16'hFFFF;
  logic [7:0]  cur_tag = '0;
  logic [7:0]  next_frag = '0;
  logic [7:0]  pend_bytes = '0;
  bit          assembling = 1'b0;
  bit          keep_bytes = 1'b0;
  bit          frag_last = 1'b0;
  logic [2:0]  frag_ch = '0;
  int          written_top = 0;

  result_t pending_reports[$];
  int  errors = 0;
  int  words_sent = 0;
  int  checked = 0;
  int  delivered = 0;
  int  settings_done = 0;
  bit  steady = 1'b0;

  function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] d);
    bit fb;
    for (int k = 7; k >= 0; k--) begin
      fb  = acc[15] ^ d[k];
      acc = {acc[14:0], 1'b0};
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic close_fragment();
    result_t r;
    r = '0;
    if (keep_bytes && frag_last) begin
      r.message_status = (rx_len == exp_len && run_crc == exp_crc) ? STAT_OK : STAT_BAD;
      r.message_length = rx_len;
      assembling = 1'b0;
    end
    keep_bytes = 1'b0;
    frag_last  = 1'b0;
    if (frag_ch == 3'd0) return;
    if (credits[frag_ch] < window) credits[frag_ch] = credits[frag_ch] + 8'd1;
    r.kind           = KIND_CREDIT;
    r.credit_channel = frag_ch;
    r.credit_count   = credits[frag_ch];
    pending_reports.push_back(r);
  endtask

  task automatic track_link_word(input item_t w);
    result_t r;
    int unsigned ch;
    r  = '0;
    ch = w.channel;
    case (w.action)
      ACT_HEADER: begin
        if (pend_bytes != 0) return;
        if (ch == 0 || ch >= NCH || credits[ch] == 0) begin
          pend_bytes       = w.payload_len;
          keep_bytes       = 1'b0;
          frag_last        = 1'b0;
          frag_ch          = '0;
          r.kind           = KIND_QFULL;
          r.credit_channel = w.channel[2:0];
          pending_reports.push_back(r);
          return;
        end
        credits[ch] = credits[ch] - 8'd1;
        frag_ch     = ch[2:0];
        keep_bytes  = 1'b0;
        frag_last   = 1'b0;
        pend_bytes  = w.payload_len;
        if (ch != net_ch || w.total_length > BUF_BYTES) begin
          assembling = 1'b0;
        end else begin
          if (w.first_flag) begin
            rx_len     = '0;
            exp_len    = w.total_length[12:0];
            exp_crc    = w.message_crc;
            cur_tag    = w.transaction;
            next_frag  = '0;
            run_crc    = seed;
            assembling = 1'b1;
          end
          if (!assembling || w.transaction != cur_tag || w.fragment_number != next_frag ||
              int'(rx_len) + int'(w.payload_len) > int'(exp_len)) begin
            assembling = 1'b0;
          end else begin
            keep_bytes = 1'b1;
            frag_last  = w.last_flag;
            next_frag  = next_frag + 8'd1;
          end
        end
        if (pend_bytes == 0) close_fragment();
      end
      ACT_DATA: begin
        if (pend_bytes == 0) return;
        if (keep_bytes && rx_len < BUF_BYTES) begin
          msg_bytes[rx_len] = w.data_byte;
          run_crc = crc_fold(run_crc, w.data_byte);
          rx_len  = rx_len + 13'd1;
          if (int'(rx_len) > written_top) written_top = rx_len;
        end
        pend_bytes = pend_bytes - 8'd1;
        if (pend_bytes == 0) close_fragment();
      end
      ACT_READ: begin
        r.kind      = KIND_READ;
        r.read_data = msg_bytes[w.read_index];
        pending_reports.push_back(r);
      end
      default: begin
        credits[0] = '0;
        for (int i = 1; i < NCH; i++) credits[i] = window;
        r.kind         = KIND_GRANT;
        r.credit_count = window;
        pending_reports.push_back(r);
      end
    endcase
  endtask

  function automatic item_t any_word();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[87:0];
  endfunction

  function automatic item_t header(input logic [7:0] ch, input logic [7:0] tag,
                                   input logic [7:0] frag, input bit first, input bit last,
                                   input logic [15:0] total, input logic [15:0] crc,
                                   input logic [7:0] dlen);
    item_t w;
    w = any_word();
    w.action          = ACT_HEADER;
    w.channel         = ch;
    w.transaction     = tag;
    w.fragment_number = frag;
    w.first_flag      = first;
    w.last_flag       = last;
    w.total_length    = total;
    w.message_crc     = crc;
    w.payload_len     = dlen;
    return w;
  endfunction

  function automatic item_t data_word(input logic [7:0] b);
    item_t w;
    w = any_word();
    w.action    = ACT_DATA;
    w.data_byte = b;
    return w;
  endfunction

  function automatic item_t read_word(input logic [11:0] idx);
    item_t w;
    w = any_word();
    w.action     = ACT_READ;
    w.read_index = idx;
    return w;
  endfunction

  function automatic item_t grant_word();
    item_t w;
    w = any_word();
    w.action = ACT_GRANT;
    return w;
  endfunction

  task automatic send_word(input item_t w);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, w.read_index, w.data_byte, w.payload_len, w.message_crc,
                 w.total_length, w.first_flag, w.fragment_number, w.transaction, w.channel};
    s_tuser  <= w.action;
    s_tlast  <= w.last_flag;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_link_word(w);
    words_sent++;
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WINDOW: window = val[7:0];
      REG_NETCH:  net_ch = val[2:0];
      default:    seed   = val[15:0];
    endcase
  endtask

  task automatic send_read();
    if (written_top == 0) send_word(grant_word());
    else send_word(read_word(12'($urandom_range(0, written_top - 1))));
  endtask

  task automatic send_side_fragment();
    logic [7:0] ch;
    logic [7:0] dlen;
    ch   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(1, NCH - 1));
    dlen = 8'($urandom_range(0, 6));
    send_word(header(ch, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                     16'($urandom), 16'($urandom), dlen));
    for (int k = 0; k < dlen; k++) send_word(data_word(8'($urandom)));
  endtask

  task automatic send_side_word();
    case ($urandom_range(0, 3))
      0: send_read();
      1: send_side_fragment();
      2: send_word(data_word(8'($urandom)));
      default: send_word(grant_word());
    endcase
  endtask

  task automatic send_message(input int lens[$], input flaw_t flaw);
    logic [7:0]  bytes_q[$];
    logic [15:0] crc;
    logic [15:0] total;
    logic [7:0]  tag;
    item_t       w;
    int          nf;
    int          pos;
    int          bad_frag;
    int          cnt;
    nf    = lens.size();
    crc   = seed;
    total = '0;
    pos   = 0;
    foreach (lens[i]) begin
      for (int k = 0; k < lens[i]; k++) begin
        bytes_q.push_back(8'($urandom));
        crc = crc_fold(crc, bytes_q[$]);
      end
      total = total + 16'(lens[i]);
    end
    tag      = 8'($urandom);
    bad_frag = $urandom_range(0, nf - 1);
    case (flaw)
      FLAW_CRC:   crc = crc ^ (16'd1 << $urandom_range(0, 15));
      FLAW_LONG:  total = total + 16'($urandom_range(1, 5));
      FLAW_SHORT: if (total != 0) total = total - 16'd1;
      default: ;
    endcase
    for (int f = 0; f < nf; f++) begin
      w = header({5'd0, net_ch}, tag, 8'(f), f == 0, f == nf - 1, total, crc, 8'(lens[f]));
      if (flaw == FLAW_ORDER && f == bad_frag) w.fragment_number = 8'(f + 1);
      if (flaw == FLAW_TAG && f == bad_frag) w.transaction = ~tag;
      if (flaw == FLAW_NOFIRST && f == 0) w.first_flag = 1'b0;
      send_word(w);
      cnt = lens[f];
      if (flaw == FLAW_CUT && f == bad_frag && cnt > 0) cnt = $urandom_range(0, cnt - 1);
      for (int k = 0; k < cnt; k++) send_word(data_word(bytes_q[pos + k]));
      pos += lens[f];
      if (f != nf - 1 && !steady && $urandom_range(0, 9) == 0) send_side_word();
    end
  endtask

  task automatic test_credit_faults();
    // no credits yet after reset, so the byte behind this header is dropped
    send_word(header(8'd1, 8'd0, 8'd0, 1'b1, 1'b1, 16'd1, 16'd0, 8'd1));
    send_word(data_word(8'hFF));
    send_word(header(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 16'd0, 16'd0, 8'd0));
    send_word(header(8'd255, 8'd0, 8'd0, 1'b1, 1'b1, 16'd0, 16'd0, 8'd0));
    send_word(grant_word());
  endtask

  task automatic test_single_message();
    logic [15:0] crc;
    crc = crc_fold(crc_fold(crc_fold(seed, 8'h00), 8'hFF), 8'h5A);
    send_word(header(8'd1, 8'hFF, 8'd0, 1'b1, 1'b1, 16'd3, crc, 8'd3));
    send_word(data_word(8'h00));
    send_word(data_word(8'hFF));
    send_word(data_word(8'h5A));
    send_word(read_word(12'd0));
    send_word(read_word(12'd1));
    send_word(read_word(12'd2));
    // empty message, crc equal to the seed, then a wrong crc
    send_word(header(8'd1, 8'h00, 8'd0, 1'b1, 1'b1, 16'd0, seed, 8'd0));
    send_word(header(8'd1, 8'h00, 8'd0, 1'b1, 1'b1, 16'd0, ~seed, 8'd0));
  endtask

  task automatic test_stray_words();
    send_word(data_word(8'h00));
    send_word(header(8'd5, 8'd1, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0, 8'd2));
    // header while bytes are pending
    send_word(header(8'd3, 8'd0, 8'd0, 1'b1, 1'b1, 16'd0, 16'd0, 8'd0));
    send_word(data_word(8'h12));
    send_word(data_word(8'h34));
    // oversize message on the network channel still returns the credit
    send_word(header(8'd1, 8'd0, 8'd0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 8'd0));
    send_word(header(8'd1, 8'hFF, 8'hFF, 1'b0, 1'b1, 16'd10, 16'd0, 8'd0));
  endtask

  task automatic test_long_message();
    int lens[$];
    lens.push_back(255);
    lens.push_back(255);
    lens.push_back(90);
    steady = 1'b1;
    send_message(lens, FLAW_NONE);
    steady = 1'b0;
    send_word(read_word(12'd599));
    send_word(read_word(12'd300));
    send_word(read_word(12'd0));
  endtask

  task automatic apply_setting(input logic [7:0] wv, input logic [2:0] nv,
                               input logic [15:0] sv);
    drain_results();
    write_reg(REG_WINDOW, {24'd0, wv});
    write_reg(REG_NETCH, {29'd0, nv});
    write_reg(REG_SEED, {16'd0, sv});
    settings_done++;
    send_word(grant_word());
  endtask

  task automatic test_random_traffic();
    int   goal;
    int   r;
    int   nf;
    int   lens[$];
    item_t w;
    flaw_t flaw;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_setting(8'd1, 3'd7, 16'h0000);
        1: apply_setting(8'd255, 3'd1, 16'hFFFF);
        2: apply_setting(8'd0, 3'd3, 16'($urandom));
        3: apply_setting(8'($urandom_range(3, 254)), 3'($urandom_range(1, 7)),
                         16'($urandom));
        4: apply_setting(8'd2, 3'd2, 16'($urandom));
        default: apply_setting(8'd4, 3'd5, 16'h1D0F);
      endcase
      goal = words_sent + 100;
      while (words_sent < goal) begin
        if ($urandom_range(0, 29) == 0) steady = ~steady;
        r = $urandom_range(0, 99);
        if (r < 55) begin
          lens.delete();
          nf = $urandom_range(1, 4);
          for (int i = 0; i < nf; i++)
            lens.push_back(($urandom_range(0, 19) == 0) ? $urandom_range(0, 60)
                                                        : $urandom_range(0, 12));
          flaw = ($urandom_range(0, 99) < 65) ? FLAW_NONE
                                              : flaw_t'($urandom_range(FLAW_CRC, FLAW_CUT));
          send_message(lens, flaw);
        end else if (r < 70) begin
          send_side_fragment();
        end else if (r < 82) begin
          send_read();
        end else if (r < 87) begin
          send_word(grant_word());
        end else if (r < 94) begin
          w = any_word();
          w.action = ACT_HEADER;
          if ($urandom_range(0, 3) != 0) w.payload_len = w.payload_len & 8'h07;
          send_word(w);
          for (int k = 0; k < w.payload_len && k < 8; k++) send_word(data_word(8'($urandom)));
        end else begin
          w = any_word();
          if (w.action == ACT_HEADER) w.payload_len = w.payload_len & 8'h03;
          if (w.action == ACT_READ) send_read();
          else send_word(w);
        end
      end
    end
    steady = 1'b0;
  endtask

  // output stall pattern
  initial begin
    int run;
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      run = steady ? 40 : $urandom_range(1, 24);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t ns: unexpected result word, kind %0d, data %h", $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("kind", want.kind, m_tuser);
        check_field("credit_channel", want.credit_channel, m_tdata[2:0]);
        check_field("credit_count", want.credit_count, m_tdata[10:3]);
        check_field("message_status", want.message_status, m_tdata[12:11]);
        check_field("message_length", want.message_length, m_tdata[25:13]);
        check_field("read_data", want.read_data, m_tdata[33:26]);
        checked++;
        if (want.message_status == STAT_OK) delivered++;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending_reports.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_credit_faults();
    test_single_message();
    test_stray_words();
    test_long_message();
    test_random_traffic();
    drain_results();
    if (pending_reports.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, pending_reports.size());
      errors += pending_reports.size();
    end
    $display("sent %0d input words across %0d register settings plus reset values",
             words_sent, settings_done);
    $display("checked %0d result words, %0d intact message deliveries", checked, delivered);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
